/* hw/rtl/bso_pkg.sv */
`default_nettype none

package bso_pkg;

    localparam int CB = 24;
    localparam int PB = 2 * CB - 1;

    typedef logic signed [CB-1:0] t_crd;
    typedef logic        [CB-2:0] t_half;
    typedef logic signed [CB:0]   t_ext;
    typedef logic signed [CB+1:0] t_ext2;

    typedef struct packed {
        logic        vert;
        logic        x_ok;
        t_crd        y0;
        t_ext        bminy;
        t_ext        bmaxy;
        t_ext        yvlo;
        t_ext        yvhi;
        logic [CB-1:0] dm;
        logic [PB-1:0] ra;
        logic [PB-1:0] rb;
        logic [CB-1:0] qa;
        logic [CB-1:0] qb;
        logic        sa;
        logic        sb;
    } t_dv;

    // one restoring quotient bit for both numerators
    function automatic t_dv dv_step(input t_dv d, input int unsigned pos);
        logic [PB-1:0] dsh;
        t_dv           r;
        r   = d;
        dsh = PB'(d.dm) << pos;
        if (d.ra >= dsh) begin
            r.ra = d.ra - dsh;
            r.qa = d.qa | (CB'(1) << pos);
        end
        if (d.rb >= dsh) begin
            r.rb = d.rb - dsh;
            r.qb = d.qb | (CB'(1) << pos);
        end
        return r;
    endfunction

    // floor quotient from magnitude, sign and remainder
    function automatic t_ext fl_quot(input logic [CB-1:0] q, input logic s,
                                     input logic [PB-1:0] rem);
        t_ext mag;
        mag = t_ext'({1'b0, q});
        if (s) begin
            if (rem != '0) begin
                mag = mag + t_ext'(1);
            end
            return -mag;
        end
        return mag;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bso_in_if.sv */
`default_nettype none

interface bso_in_if
    import bso_pkg::*;
;
    logic  valid;
    logic  ready;
    t_crd  box_center_x;
    t_crd  box_center_y;
    t_half box_half_width;
    t_half box_half_height;
    t_crd  seg_start_x;
    t_crd  seg_start_y;
    t_crd  seg_dx;
    t_crd  seg_dy;

    modport source (
        output valid, box_center_x, box_center_y, box_half_width, box_half_height,
               seg_start_x, seg_start_y, seg_dx, seg_dy,
        input  ready
    );
    modport sink (
        input  valid, box_center_x, box_center_y, box_half_width, box_half_height,
               seg_start_x, seg_start_y, seg_dx, seg_dy,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/bso_out_if.sv */
`default_nettype none

interface bso_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/box_segment_overlap.sv */
// channel  | dir | word
// i_in     | in  | box center, half sizes, segment start and vector
// o_out    | out | hit
//
// One word accepted per cycle unless a waiting output word holds the pipeline.
// Depth set by the restoring divider: one quotient bit per stage.
// Synchronous active-low reset clears the valid bits only.
// The whole pipeline holds while the output word waits; nothing is lost.
`default_nettype none

module box_segment_overlap
    import bso_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    bso_in_if.sink   i_in,
    bso_out_if.source o_out
);

    localparam int NS = CB + 5;

    typedef struct packed {
        logic vert;
        logic x_ok;
        t_crd y0;
        t_crd dy;
        t_crd dx;
        t_ext ta;
        t_ext tb;
        t_ext bminy;
        t_ext bmaxy;
        t_ext yvlo;
        t_ext yvhi;
    } t_front;

    logic [NS-1:0] r_v;
    logic          en;
    logic          in_acc;

    assign en          = !r_v[NS-1] || o_out.ready;
    assign i_in.ready  = en;
    assign in_acc      = i_in.valid && en;

    // stage 1: bounds, x clip
    t_ext   sx0, sy0, bminx, bmaxx, x1, y1, xlo0, xhi0, xlo, xhi;
    t_ext2  ta_w, tb_w;
    t_front n_f1, r_f1;

    always_comb begin
        sx0   = {i_in.seg_start_x[CB-1], i_in.seg_start_x};
        sy0   = {i_in.seg_start_y[CB-1], i_in.seg_start_y};
        bminx = t_ext'({i_in.box_center_x[CB-1], i_in.box_center_x})
              - t_ext'({2'b00, i_in.box_half_width});
        bmaxx = t_ext'({i_in.box_center_x[CB-1], i_in.box_center_x})
              + t_ext'({2'b00, i_in.box_half_width});
        x1    = sx0 + t_ext'({i_in.seg_dx[CB-1], i_in.seg_dx});
        y1    = sy0 + t_ext'({i_in.seg_dy[CB-1], i_in.seg_dy});
        xlo0  = i_in.seg_dx[CB-1] ? x1 : sx0;
        xhi0  = i_in.seg_dx[CB-1] ? sx0 : x1;
        xlo   = (xlo0 < bminx) ? bminx : xlo0;
        xhi   = (xhi0 > bmaxx) ? bmaxx : xhi0;
        ta_w  = t_ext2'({xlo[CB], xlo}) - t_ext2'({sx0[CB], sx0});
        tb_w  = t_ext2'({xhi[CB], xhi}) - t_ext2'({sx0[CB], sx0});
        n_f1.vert  = (i_in.seg_dx == '0);
        n_f1.x_ok  = n_f1.vert ? ((sx0 > bminx) && (sx0 < bmaxx)) : (xlo < xhi);
        n_f1.y0    = i_in.seg_start_y;
        n_f1.dy    = i_in.seg_dy;
        n_f1.dx    = i_in.seg_dx;
        n_f1.ta    = ta_w[CB:0];
        n_f1.tb    = tb_w[CB:0];
        n_f1.bminy = t_ext'({i_in.box_center_y[CB-1], i_in.box_center_y})
                   - t_ext'({2'b00, i_in.box_half_height});
        n_f1.bmaxy = t_ext'({i_in.box_center_y[CB-1], i_in.box_center_y})
                   + t_ext'({2'b00, i_in.box_half_height});
        n_f1.yvlo  = i_in.seg_dy[CB-1] ? y1 : sy0;
        n_f1.yvhi  = i_in.seg_dy[CB-1] ? sy0 : y1;
    end

    // stage 2: products
    logic signed [2*CB:0] n_pa, n_pb, r_pa, r_pb;
    t_front               r_f2;

    assign n_pa = r_f1.dy * r_f1.ta;
    assign n_pb = r_f1.dy * r_f1.tb;

    // stage 3: magnitudes and signs into divider
    logic signed [2*CB:0] ma, mb;
    logic [CB-1:0]        dmag;
    t_dv                  n_dv [0:CB];
    t_dv                  r_dv [0:CB];

    always_comb begin
        ma   = r_pa[2*CB] ? -r_pa : r_pa;
        mb   = r_pb[2*CB] ? -r_pb : r_pb;
        dmag = r_f2.dx[CB-1] ? CB'(-r_f2.dx) : CB'(r_f2.dx);
        n_dv[0].vert  = r_f2.vert;
        n_dv[0].x_ok  = r_f2.x_ok;
        n_dv[0].y0    = r_f2.y0;
        n_dv[0].bminy = r_f2.bminy;
        n_dv[0].bmaxy = r_f2.bmaxy;
        n_dv[0].yvlo  = r_f2.yvlo;
        n_dv[0].yvhi  = r_f2.yvhi;
        n_dv[0].dm    = dmag;
        n_dv[0].ra    = ma[PB-1:0];
        n_dv[0].rb    = mb[PB-1:0];
        n_dv[0].qa    = '0;
        n_dv[0].qb    = '0;
        n_dv[0].sa    = r_pa[2*CB] ^ r_f2.dx[CB-1];
        n_dv[0].sb    = r_pb[2*CB] ^ r_f2.dx[CB-1];
    end

    for (genvar k = 1; k <= CB; k++) begin : g_div
        assign n_dv[k] = dv_step(r_dv[k-1], (CB - k));
    end

    // fix stage: y at clipped bounds, ordering
    t_dv    dl;
    t_ext   qa_f, qb_f;
    t_ext2  ya, yb, n_lo, n_hi, r_lo, r_hi;
    t_ext   r_bminy, r_bmaxy;
    logic   r_xok;

    always_comb begin
        dl   = r_dv[CB];
        qa_f = fl_quot(dl.qa, dl.sa, dl.ra);
        qb_f = fl_quot(dl.qb, dl.sb, dl.rb);
        ya   = t_ext2'(dl.y0) + t_ext2'(qa_f);
        yb   = t_ext2'(dl.y0) + t_ext2'(qb_f);
        if (dl.vert) begin
            n_lo = t_ext2'(dl.yvlo);
            n_hi = t_ext2'(dl.yvhi);
        end else if (ya <= yb) begin
            n_lo = ya;
            n_hi = yb;
        end else begin
            n_lo = yb;
            n_hi = ya;
        end
    end

    // output stage: y clip
    t_ext2 clo, chi;
    logic  n_hit, r_hit;

    always_comb begin
        clo   = (r_lo < t_ext2'(r_bminy)) ? t_ext2'(r_bminy) : r_lo;
        chi   = (r_hi > t_ext2'(r_bmaxy)) ? t_ext2'(r_bmaxy) : r_hi;
        n_hit = r_xok && (clo < chi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1 <= n_f1;
            r_f2 <= r_f1;
            r_pa <= n_pa;
            r_pb <= n_pb;
            for (int k = 0; k <= CB; k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_bminy <= dl.bminy;
            r_bmaxy <= dl.bmaxy;
            r_xok   <= dl.x_ok;
            r_hit   <= n_hit;
        end
    end

    assign o_out.valid = r_v[NS-1];
    assign o_out.hit   = r_hit;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> (r_v == '0))
        else $error("valid bits not cleared by reset");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[0])
        else $error("accepted word not in first stage");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipeline moved while stalled");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !in_acc) |=> ($countones(r_v) <= $past($countones(r_v))))
        else $error("word invented in pipeline");

endmodule

`default_nettype wire

/* tb/sv/tb_box_segment_overlap.sv */
`timescale 1ns / 1ps

module tb_box_segment_overlap;
    import bso_pkg::*;

    localparam int LATENCY   = CB + 5;
    localparam int MAX_CYC   = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bso_in_if  in_ch();
    bso_out_if out_ch();

    box_segment_overlap DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    typedef struct {
        t_crd  cx;
        t_crd  cy;
        t_half hw;
        t_half hh;
        t_crd  x0;
        t_crd  y0;
        t_crd  dx;
        t_crd  dy;
    } t_query;

    logic hit_q[$];
    int   mismatches = 0;
    int   cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.box_center_x = '0;
        in_ch.box_center_y = '0;
        in_ch.box_half_width = '0;
        in_ch.box_half_height = '0;
        in_ch.seg_start_x = '0;
        in_ch.seg_start_y = '0;
        in_ch.seg_dx = '0;
        in_ch.seg_dy = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        longint r;
        q = n / d;
        r = n % d;
        if (r != 0 && ((r < 0) != (d < 0))) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic logic predict_hit(t_query q);
        longint cx, cy, hw, hh, x0, y0, dx, dy;
        longint bminx, bmaxx, bminy, bmaxy, ylo, yhi, xlo, xhi, ya, yb;
        cx = q.cx; cy = q.cy; hw = q.hw; hh = q.hh;
        x0 = q.x0; y0 = q.y0; dx = q.dx; dy = q.dy;
        bminx = cx - hw; bmaxx = cx + hw;
        bminy = cy - hh; bmaxy = cy + hh;
        if (dx == 0) begin
            if (x0 <= bminx || x0 >= bmaxx) begin
                return 1'b0;
            end
            ylo = (dy > 0) ? y0 : y0 + dy;
            yhi = (dy > 0) ? y0 + dy : y0;
        end else begin
            xlo = (dx > 0) ? x0 : x0 + dx;
            xhi = (dx > 0) ? x0 + dx : x0;
            if (xhi > bmaxx) xhi = bmaxx;
            if (xlo < bminx) xlo = bminx;
            if (xlo >= xhi) begin
                return 1'b0;
            end
            ya = y0 + floor_quot(dy * (xlo - x0), dx);
            yb = y0 + floor_quot(dy * (xhi - x0), dx);
            ylo = (ya <= yb) ? ya : yb;
            yhi = (ya <= yb) ? yb : ya;
        end
        if (yhi > bmaxy) yhi = bmaxy;
        if (ylo < bminy) ylo = bminy;
        return ylo < yhi;
    endfunction

    task automatic send_query(t_query q);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.box_center_x <= q.cx;
        in_ch.box_center_y <= q.cy;
        in_ch.box_half_width <= q.hw;
        in_ch.box_half_height <= q.hh;
        in_ch.seg_start_x <= q.x0;
        in_ch.seg_start_y <= q.y0;
        in_ch.seg_dx <= q.dx;
        in_ch.seg_dy <= q.dy;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        hit_q.push_back(predict_hit(q));
    endtask

    // receive side: random stall per word, check at accept
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            if (hit_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word hit=%0b", out_ch.hit);
            end else begin
                logic exp_hit;
                exp_hit = hit_q.pop_front();
                if (out_ch.hit !== exp_hit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: expected %0b actual %0b", exp_hit, out_ch.hit);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("box_segment_overlap test failed");
            $finish;
        end
    end

    function automatic t_crd rand_crd();
        return t_crd'($urandom());
    endfunction

    function automatic t_crd near_crd(t_crd c, int span);
        return t_crd'(c + $urandom_range(0, 2 * span) - span);
    endfunction

    task automatic test_directed();
        t_query q;
        q = '{0, 0, 256, 256, -512, 0, 1024, 0};
        send_query(q);
        q = '{0, 0, 256, 256, 0, -512, 0, 1024};
        send_query(q);
        q = '{0, 0, 256, 256, 256, -512, 0, 1024};
        send_query(q);
        q = '{0, 0, 256, 256, -256, -512, 0, 1024};
        send_query(q);
        q = '{0, 0, 0, 256, -512, 0, 1024, 0};
        send_query(q);
        q = '{0, 0, 256, 0, -512, 0, 1024, 0};
        send_query(q);
        q = '{0, 0, 256, 256, -512, 256, 1024, 0};
        send_query(q);
        q = '{0, 0, 256, 256, -512, -512, 1024, 1024};
        send_query(q);
        q = '{0, 0, 256, 256, 512, 512, -1024, -1024};
        send_query(q);
        q = '{0, 0, 256, 256, -512, 512, 1024, -1024};
        send_query(q);
        q = '{0, 0, 256, 256, -1000, 3, 7, 5};
        send_query(q);
        q = '{0, 0, 256, 256, 256, 0, 100, 0};
        send_query(q);
        q = '{24'sh7fffff, 24'sh7fffff, 23'h7fffff, 23'h7fffff,
              24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff};
        send_query(q);
        q = '{24'sh800000, 24'sh800000, 23'h7fffff, 23'h7fffff,
              24'sh7fffff, 24'sh7fffff, 24'sh800000, 24'sh800000};
        send_query(q);
        q = '{24'sh7fffff, 24'sh800000, 23'h7fffff, 23'h7fffff,
              24'sh800000, 24'sh7fffff, 24'sh7fffff, 24'sh800000};
        send_query(q);
        q = '{0, 0, 23'h7fffff, 23'h7fffff, 0, 0, 24'sh800000, 24'sh7fffff};
        send_query(q);
        q = '{0, 0, 23'h7fffff, 23'h7fffff, 0, 0, 1, 24'sh800000};
        send_query(q);
        q = '{0, 0, 23'h7fffff, 23'h7fffff, 0, 0, -1, 24'sh7fffff};
        send_query(q);
        q = '{0, 0, 1, 1, 0, 0, 0, 1};
        send_query(q);
        q = '{0, 0, 256, 256, -300, 100, 3, -7};
        send_query(q);
    endtask

    task automatic test_drain_pause();
        in_ch.valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random(int count);
        t_query q;
        int mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9);
            q.cx = rand_crd();
            q.cy = rand_crd();
            q.hw = t_half'($urandom());
            q.hh = t_half'($urandom());
            q.x0 = rand_crd();
            q.y0 = rand_crd();
            q.dx = rand_crd();
            q.dy = rand_crd();
            if (mode < 6) begin
                // segment and box at comparable scale, near each other
                q.hw = t_half'($urandom_range(0, 4096));
                q.hh = t_half'($urandom_range(0, 4096));
                q.x0 = near_crd(q.cx, 6000);
                q.y0 = near_crd(q.cy, 6000);
                q.dx = t_crd'($urandom_range(0, 16000) - 8000);
                q.dy = t_crd'($urandom_range(0, 16000) - 8000);
                if (mode == 0) q.dx = '0;
                if (mode == 1) q.dy = '0;
            end else if (mode == 6) begin
                q.dx = t_crd'($urandom_range(0, 6) - 3);
            end
            send_query(q);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_drain_pause();
        test_random(830);
        in_ch.valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("box_segment_overlap test passed");
        end else begin
            $display("box_segment_overlap test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bso_pkg.sv
hw/rtl/bso_in_if.sv
hw/rtl/bso_out_if.sv
hw/rtl/box_segment_overlap.sv
tb/sv/tb_box_segment_overlap.sv
